FILE: sv/epoc_pkg.sv
// shared constants and types for the exact pattern occurrence counter
`default_nettype none

package epoc_pkg;

  // default depth of the pattern store and the text window
  localparam int unsigned MAX_PATTERN_DEF = 64;

  // payload widths fixed by the item format
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;

  // opcode values of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // compare stage result handed to the count stage
  typedef struct packed {
    logic valid;
    logic hit;
    logic last;
  } epoc_s1_t;

endpackage

`default_nettype wire

FILE: sv/epoc_if.sv
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface epoc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [epoc_pkg::BYTE_W-1:0] data_byte;
  logic                       last_item;

  modport source (output valid, opcode, data_byte, last_item, input ready);
  modport sink   (input valid, opcode, data_byte, last_item, output ready);
endinterface

interface epoc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        match_here;
  logic [epoc_pkg::COUNT_W-1:0] match_count;
  logic                        text_done;

  modport source (output valid, match_here, match_count, text_done, input ready);
  modport sink   (input valid, match_here, match_count, text_done, output ready);
endinterface

`default_nettype wire

FILE: sv/exact_pattern_occurrence_count_core.sv
// top level of the exact pattern occurrence counter
// a text item's compare result is registered in the compare stage, and its count
//   and result in the result register of the count stage
// throughput: one item per cycle while results are taken; the MaxPattern-wide
//   parallel window compare and the 32-bit count increment each fill one stage
// pattern load items produce no result
// reset clears pattern length, load index, bytes seen, count and stage valids;
//   pattern and window contents are not reset
`default_nettype none

module exact_pattern_occurrence_count_core #(
  parameter int unsigned MaxPattern = epoc_pkg::MAX_PATTERN_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  epoc_in_if.sink     in_if,
  epoc_out_if.source  out_if
);
  import epoc_pkg::*;

  epoc_s1_t s1;
  logic     s1_ready;

  // shift window and compare
  epoc_match #(
    .MaxPattern (MaxPattern)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .s1_ready (s1_ready),
    .s1_r     (s1)
  );

  // count and deliver results
  epoc_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1),
    .s1_ready (s1_ready),
    .out_if   (out_if)
  );

  // a reported occurrence always leaves a nonzero count
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.match_here) |-> (out_if.match_count != '0))
    else $error("match reported with zero count");

  // input stalls only when both stages are full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1.valid && out_if.valid && !out_if.ready))
    else $error("input stalled with a free stage");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: sv/epoc_match.sv
// pattern shift register, text window and parallel window compare
`default_nettype none

module epoc_match #(
  parameter int unsigned MaxPattern = epoc_pkg::MAX_PATTERN_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  epoc_in_if.sink             in_if,
  input  wire logic           s1_ready,
  output epoc_pkg::epoc_s1_t  s1_r
);
  import epoc_pkg::*;

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  // pattern held newest-first: entry 0 is the final pattern byte
  logic [BYTE_W-1:0] pat_r   [MaxPattern];
  // text window: entry 0 is the newest text byte
  logic [BYTE_W-1:0] win_r   [MaxPattern];
  logic [BYTE_W-1:0] win_nxt [MaxPattern];

  logic [LenW-1:0] pat_len_r, pat_len_nxt;
  logic [LenW-1:0] load_idx_r, load_idx_nxt;
  logic [LenW-1:0] seen_r, seen_nxt;

  logic take, take_load, take_text, shift_en, all_eq, hit;

  assign in_if.ready = !s1_r.valid || s1_ready;
  assign take      = in_if.valid && in_if.ready;
  assign take_load = take && (in_if.opcode == OP_LOAD);
  assign take_text = take && (in_if.opcode == OP_TEXT);

  // window after the incoming byte shifts in
  always_comb begin
    win_nxt[0] = in_if.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // bytes in the window, saturating at the window depth
  assign seen_nxt = (seen_r == LenW'(MaxPattern)) ? seen_r : seen_r + 1'b1;

  // compare every window byte against its pattern byte, masked by length
  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      if ((LenW'(k) < pat_len_r) && (win_nxt[k] != pat_r[k])) begin
        all_eq = 1'b0;
      end
    end
    hit = (pat_len_r != '0) && (seen_nxt >= pat_len_r) && all_eq;
  end

  // pattern load bookkeeping
  always_comb begin
    pat_len_nxt  = pat_len_r;
    load_idx_nxt = load_idx_r;
    shift_en     = 1'b0;
    if (load_idx_r == '0) begin
      pat_len_nxt = '0;
    end
    if (load_idx_r < LenW'(MaxPattern)) begin
      shift_en     = 1'b1;
      load_idx_nxt = load_idx_r + 1'b1;
    end
    if (in_if.last_item) begin
      pat_len_nxt  = load_idx_nxt;
      load_idx_nxt = '0;
    end
  end

  // pattern shift register
  always_ff @(posedge clk) begin
    if (take_load && shift_en) begin
      pat_r[0] <= in_if.data_byte;
      for (int k = 1; k < MaxPattern; k++) begin
        pat_r[k] <= pat_r[k-1];
      end
    end
  end

  // text window shift register
  always_ff @(posedge clk) begin
    if (take_text) begin
      win_r <= win_nxt;
    end
  end

  // control state and compare result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      load_idx_r <= '0;
      seen_r     <= '0;
      s1_r       <= '0;
    end else begin
      if (take_load) begin
        pat_len_r  <= pat_len_nxt;
        load_idx_r <= load_idx_nxt;
      end
      if (take_text) begin
        seen_r <= in_if.last_item ? '0 : seen_nxt;
      end
      if (take_text) begin
        s1_r.valid <= 1'b1;
        s1_r.hit   <= hit;
        s1_r.last  <= in_if.last_item;
      end else if (s1_ready) begin
        s1_r.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/epoc_count.sv
// saturating occurrence count and result register
`default_nettype none

module epoc_count (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire epoc_pkg::epoc_s1_t s1,
  output logic                    s1_ready,
  epoc_out_if.source              out_if
);
  import epoc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_valid_r, out_match_r, out_done_r;
  logic               take;

  assign s1_ready = !out_valid_r || out_if.ready;
  assign take     = s1.valid && s1_ready;

  // saturating increment on a hit
  assign count_nxt = (s1.hit && (count_r != '1)) ? count_r + 1'b1 : count_r;

  // running count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        count_r     <= s1.last ? '0 : count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_match_r <= s1.hit;
      out_count_r <= count_nxt;
      out_done_r  <= s1.last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.match_here  = out_match_r;
  assign out_if.match_count = out_count_r;
  assign out_if.text_done   = out_done_r;

endmodule

`default_nettype wire
